>>> rtl/core/qr_function_pattern_map_unit_assert.svh
// assertion macros for the qr function pattern map rtl
`ifndef QR_FUNCTION_PATTERN_MAP_UNIT_ASSERT_SVH
`define QR_FUNCTION_PATTERN_MAP_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define QRFPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/qrfpm_pkg.sv
// ----------------------------------------------------------------------------
// qrfpm_pkg
// Types, version tables and helpers for the qr function pattern classifier.
// ----------------------------------------------------------------------------
package qrfpm_pkg;

  localparam int unsigned VerW = 6;
  localparam int unsigned CoordW = 8;
  localparam logic [VerW-1:0] MAX_VERSION = 6'd40;
  localparam logic [VerW-1:0] VERSION_RESET = 6'd1;
  localparam int unsigned NumCentres = 6;

  typedef enum logic [1:0] {
    CLS_DATA  = 2'd0,
    CLS_LIGHT = 2'd1,
    CLS_DARK  = 2'd2,
    CLS_RSVD  = 2'd3
  } module_class_e;

  // settings derived from the version register
  typedef struct packed {
    logic [CoordW-1:0]                 width;
    logic [2:0]                        klast;
    logic                              align_en;
    logic                              verblk_en;
    logic [17:0]                       verword;
    logic [NumCentres:1][CoordW-1:0]   centre;
  } cfg_t;

  // result of matching one coordinate against the alignment centres
  typedef struct packed {
    logic       found;
    logic [2:0] idx;
    logic [1:0] offs;
  } axis_t;

  // second alignment coordinate per version
  localparam logic [7:0] ALIGN_A0 [41] = '{
    8'd0,
    8'd0,  8'd18, 8'd22, 8'd26, 8'd30, 8'd34, 8'd22, 8'd24, 8'd26, 8'd28,
    8'd30, 8'd32, 8'd34, 8'd26, 8'd26, 8'd26, 8'd30, 8'd30, 8'd30, 8'd34,
    8'd28, 8'd26, 8'd30, 8'd28, 8'd32, 8'd30, 8'd34, 8'd26, 8'd30, 8'd26,
    8'd30, 8'd34, 8'd30, 8'd34, 8'd30, 8'd24, 8'd28, 8'd32, 8'd26, 8'd30
  };

  // third alignment coordinate per version, zero where there is none
  localparam logic [7:0] ALIGN_A1 [41] = '{
    8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd38, 8'd42, 8'd46, 8'd50,
    8'd54, 8'd58, 8'd62, 8'd46, 8'd48, 8'd50, 8'd54, 8'd56, 8'd58, 8'd62,
    8'd50, 8'd50, 8'd54, 8'd54, 8'd58, 8'd58, 8'd62, 8'd50, 8'd54, 8'd52,
    8'd56, 8'd60, 8'd58, 8'd62, 8'd54, 8'd50, 8'd54, 8'd58, 8'd54, 8'd58
  };

  // bch version words, zero below version 7
  localparam logic [17:0] VERWORD [41] = '{
    18'h00000, 18'h00000, 18'h00000, 18'h00000, 18'h00000, 18'h00000, 18'h00000,
    18'h07c94, 18'h085bc, 18'h09a99, 18'h0a4d3, 18'h0bbf6, 18'h0c762, 18'h0d847,
    18'h0e60d, 18'h0f928, 18'h10b78, 18'h1145d, 18'h12a17, 18'h13532, 18'h149a6,
    18'h15683, 18'h168c9, 18'h177ec, 18'h18ec4, 18'h191e1, 18'h1afab, 18'h1b08e,
    18'h1cc1a, 18'h1d33f, 18'h1ed75, 18'h1f250, 18'h209d5, 18'h216f0, 18'h228ba,
    18'h2379f, 18'h24b0b, 18'h2542e, 18'h26a64, 18'h27541, 18'h28c69
  };

  function automatic cfg_t cfg_derive(logic [VerW-1:0] ver);
    logic [VerW-1:0]   v;
    logic [CoordW-1:0] a0;
    logic [CoordW-1:0] a1;
    logic [CoordW-1:0] d;
    logic [CoordW-1:0] pos;
    cfg_t              c;
    v = ver;
    if (v == '0) begin
      v = 6'd1;
    end else if (v > MAX_VERSION) begin
      v = MAX_VERSION;
    end
    c.width = 8'd17 + {v, 2'b00};
    a0 = ALIGN_A0[v];
    a1 = ALIGN_A1[v];
    d = (a1 > a0) ? (a1 - a0) : '0;
    if (v >= 6'd35) begin
      c.klast = 3'd6;
    end else if (v >= 6'd28) begin
      c.klast = 3'd5;
    end else if (v >= 6'd21) begin
      c.klast = 3'd4;
    end else if (v >= 6'd14) begin
      c.klast = 3'd3;
    end else if (v >= 6'd7) begin
      c.klast = 3'd2;
    end else begin
      c.klast = 3'd1;
    end
    pos = a0;
    for (int k = 1; k <= NumCentres; k++) begin
      c.centre[k] = pos;
      pos = pos + d;
    end
    c.align_en = (v >= 6'd2);
    c.verblk_en = (v >= 6'd7);
    c.verword = VERWORD[v];
    return c;
  endfunction

  // finder ring: light on the ring two away from the centre, dark elsewhere
  function automatic module_class_e finder_cls(logic [2:0] fx, logic [2:0] fy);
    logic [1:0] dx;
    logic [1:0] dy;
    dx = (fx >= 3'd3) ? 2'(fx - 3'd3) : 2'(3'd3 - fx);
    dy = (fy >= 3'd3) ? 2'(fy - 3'd3) : 2'(3'd3 - fy);
    return ((dx == 2'd2 && dy <= 2'd2) || (dy == 2'd2 && dx <= 2'd2)) ?
           CLS_LIGHT : CLS_DARK;
  endfunction

endpackage

>>> rtl/core/qrfpm_cfg.sv
// ----------------------------------------------------------------------------
// qrfpm_cfg
// Version register; holds the pattern geometry derived from the written version.
// ----------------------------------------------------------------------------
module qrfpm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qrfpm_pkg::VerW-1:0]  cfg_wdata_i,
  output qrfpm_pkg::cfg_t             cfg_o
);
  import qrfpm_pkg::*;

  localparam cfg_t CfgReset = cfg_derive(VERSION_RESET);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_d = cfg_we_i ? cfg_derive(cfg_wdata_i) : cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/qrfpm_class.sv
// ----------------------------------------------------------------------------
// qrfpm_class
// Classifies one module coordinate against the empty symbol template.
// ----------------------------------------------------------------------------
module qrfpm_class (
  input  qrfpm_pkg::cfg_t               cfg_i,
  input  logic [qrfpm_pkg::CoordW-1:0]  col_i,
  input  logic [qrfpm_pkg::CoordW-1:0]  row_i,
  output qrfpm_pkg::module_class_e      cls_o,
  output logic                          outside_o
);
  import qrfpm_pkg::*;

  // lowest-index alignment centre within two of t
  function automatic axis_t align_axis(logic [CoordW-1:0] t, cfg_t c);
    axis_t             a;
    logic [CoordW-1:0] ctr;
    logic signed [8:0] diff;
    logic signed [8:0] mag;
    a = '0;
    for (int k = NumCentres; k >= 0; k--) begin
      ctr = (k == 0) ? 8'd6 : c.centre[(k == 0) ? 1 : k];
      diff = $signed({1'b0, t}) - $signed({1'b0, ctr});
      mag = diff[8] ? -diff : diff;
      if ((k == 0 || 3'(k) <= c.klast) && mag <= 9'sd2) begin
        a.found = 1'b1;
        a.idx = 3'(k);
        a.offs = mag[1:0];
      end
    end
    return a;
  endfunction

  logic [CoordW-1:0] w7, w8, w9, w11;
  axis_t             ax, ay;
  logic              vb_col, vb_row;
  logic [4:0]        vb_idx;
  logic [31:0]       vw_ext;
  module_class_e     cls;

  assign w7  = cfg_i.width - 8'd7;
  assign w8  = cfg_i.width - 8'd8;
  assign w9  = cfg_i.width - 8'd9;
  assign w11 = cfg_i.width - 8'd11;

  assign ax = align_axis(col_i, cfg_i);
  assign ay = align_axis(row_i, cfg_i);

  // bottom-left block runs down columns, top-right block along rows
  assign vb_col = (col_i <= 8'd5) && (row_i >= w11) && (row_i <= w9);
  assign vb_row = (row_i <= 8'd5) && (col_i >= w11) && (col_i <= w9);
  assign vw_ext = {14'd0, cfg_i.verword};

  always_comb begin
    if (vb_row) begin
      vb_idx = 5'({row_i[2:0], 1'b0}) + 5'(row_i[2:0]) + 5'(col_i - w11);
    end else begin
      vb_idx = 5'({col_i[2:0], 1'b0}) + 5'(col_i[2:0]) + 5'(row_i - w11);
    end
  end

  always_comb begin
    cls = CLS_DATA;

    // finders
    if (col_i <= 8'd6 && row_i <= 8'd6) begin
      cls = finder_cls(col_i[2:0], row_i[2:0]);
    end
    if (col_i >= w7 && row_i <= 8'd6) begin
      cls = finder_cls(3'(col_i - w7), row_i[2:0]);
    end
    if (col_i <= 8'd6 && row_i >= w7) begin
      cls = finder_cls(col_i[2:0], 3'(row_i - w7));
    end

    // separators
    if ((col_i == 8'd7 && row_i <= 8'd6) || (col_i == w8 && row_i <= 8'd6) ||
        (col_i == 8'd7 && row_i >= w7) || (row_i == 8'd7 && col_i <= 8'd7) ||
        (row_i == 8'd7 && col_i >= w8) || (row_i == w8 && col_i <= 8'd7)) begin
      cls = CLS_LIGHT;
    end

    // format reserve
    if ((row_i == 8'd8 && col_i <= 8'd8) || (row_i == 8'd8 && col_i >= w8) ||
        (col_i == 8'd8 && row_i <= 8'd7) || (col_i == 8'd8 && row_i >= w7)) begin
      cls = CLS_RSVD;
    end

    // timing lines, dark on even coordinates
    if (row_i == 8'd6 && col_i >= 8'd8 && col_i <= w9) begin
      cls = col_i[0] ? CLS_LIGHT : CLS_DARK;
    end
    if (col_i == 8'd6 && row_i >= 8'd8 && row_i <= w9) begin
      cls = row_i[0] ? CLS_LIGHT : CLS_DARK;
    end

    // alignment patterns, skipping the three finder corners
    if (cfg_i.align_en && ax.found && ay.found &&
        !(ax.idx == 3'd0 && ay.idx == 3'd0) &&
        !(ax.idx == 3'd0 && ay.idx == cfg_i.klast) &&
        !(ax.idx == cfg_i.klast && ay.idx == 3'd0)) begin
      cls = (ax.offs <= 2'd1 && ay.offs <= 2'd1 &&
             (ax.offs == 2'd1 || ay.offs == 2'd1)) ? CLS_LIGHT : CLS_DARK;
    end

    // version blocks
    if (cfg_i.verblk_en && (vb_col || vb_row)) begin
      cls = vw_ext[vb_idx] ? CLS_DARK : CLS_LIGHT;
    end

    // fixed dark module
    if (col_i == 8'd8 && row_i == w8) begin
      cls = CLS_DARK;
    end
  end

  assign outside_o = (col_i >= cfg_i.width) || (row_i >= cfg_i.width);
  assign cls_o = outside_o ? CLS_DATA : cls;

endmodule

>>> rtl/core/qr_function_pattern_map_unit.sv
// ----------------------------------------------------------------------------
// qr_function_pattern_map_unit
// Maps module coordinates to their class in the empty qr symbol template.
// ----------------------------------------------------------------------------
// Takes one coordinate word per clock and returns one class word per clock;
// a class word is valid on the output after its coordinate is accepted and
// has passed both stages: the coordinate lands in an input register, one pass
// of comparators and table selects classifies it, and the result register holds
// it for the output side. Back-pressure on the output stalls both stages;
// an empty stage keeps taking words. The version register sets the symbol width
// and pattern positions from the next clock on; values of 0 act as version 1
// and values above 40 as version 40. Coordinates beyond the symbol width come
// out with the outside flag set and the data class.
`include "qr_function_pattern_map_unit_assert.svh"

module qr_function_pattern_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // col [7:0], row [15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // module_class [1:0], zero [7:2]
  output logic        m_axis_tuser    // outside [0]
);
  import qrfpm_pkg::*;

  cfg_t              cfg;
  logic              s1_valid_q, s1_valid_d;
  logic [CoordW-1:0] col_q, row_q;
  logic              m_valid_q, m_valid_d;
  module_class_e     cls_q, cls_c;
  logic              outside_q, outside_c;
  logic              advance;
  logic              in_fire;

  qrfpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  qrfpm_class u_class (
    .cfg_i     (cfg),
    .col_i     (col_q),
    .row_i     (row_q),
    .cls_o     (cls_c),
    .outside_o (outside_c)
  );

  // result stage frees up when empty or being taken
  assign advance = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d = s_axis_tready ? s_axis_tvalid : s1_valid_q;
  assign m_valid_d = advance ? s1_valid_q : m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= s_axis_tdata[7:0];
      row_q <= s_axis_tdata[15:8];
    end
    if (advance && s1_valid_q) begin
      cls_q     <= cls_c;
      outside_q <= outside_c;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, cls_q};
  assign m_axis_tuser  = outside_q;

  `QRFPM_ASSERT_NOW(a_outside_is_data, m_valid_q && outside_q, cls_q == CLS_DATA, "outside word carries a non-data class")
  `QRFPM_ASSERT_NOW(a_ready_follows_out, m_axis_tready, s_axis_tready, "input stalled while output side is taking words")
  `QRFPM_ASSERT_NEXT(a_stage_moves, s1_valid_q && advance, m_valid_q, "input stage word lost on its way to the result register")
  `QRFPM_ASSERT_NEXT(a_stage_holds, s1_valid_q && !advance, s1_valid_q, "input stage dropped a word while stalled")

endmodule

>>> verif/qr_function_pattern_map_unit_test.sv
// ----------------------------------------------------------------------------
// qr_function_pattern_map_unit_test
// Self-checking bench for the qr function pattern classifier. A local model of
// the symbol template predicts the class and outside flag of every coordinate
// word sent; each output word is checked in order against those predictions.
// Directed coordinates cover the pattern corners, the version limits and the
// out-of-range register values. Random phases sweep many versions with
// coordinates biased toward finder, timing, alignment and version areas.
// ----------------------------------------------------------------------------
module qr_function_pattern_map_unit_test;
  import qrfpm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 70;
  localparam int NUM_PHASES = 16;

  // second and third alignment coordinate per version (0 = absent)
  localparam int CENTRE_2ND [41] = '{
    0,
    0,  18, 22, 26, 30, 34, 22, 24, 26, 28,
    30, 32, 34, 26, 26, 26, 30, 30, 30, 34,
    28, 26, 30, 28, 32, 30, 34, 26, 30, 26,
    30, 34, 30, 34, 30, 24, 28, 32, 26, 30
  };
  localparam int CENTRE_3RD [41] = '{
    0,
    0,  0,  0,  0,  0,  0,  38, 42, 46, 50,
    54, 58, 62, 46, 48, 50, 54, 56, 58, 62,
    50, 50, 54, 54, 58, 58, 62, 50, 54, 52,
    56, 60, 58, 62, 54, 50, 54, 58, 54, 58
  };

  // bch version words for versions 7 to 40
  localparam logic [17:0] VERSION_WORDS [34] = '{
    18'h07c94, 18'h085bc, 18'h09a99, 18'h0a4d3, 18'h0bbf6, 18'h0c762, 18'h0d847,
    18'h0e60d, 18'h0f928, 18'h10b78, 18'h1145d, 18'h12a17, 18'h13532, 18'h149a6,
    18'h15683, 18'h168c9, 18'h177ec, 18'h18ec4, 18'h191e1, 18'h1afab, 18'h1b08e,
    18'h1cc1a, 18'h1d33f, 18'h1ed75, 18'h1f250, 18'h209d5, 18'h216f0, 18'h228ba,
    18'h2379f, 18'h24b0b, 18'h2542e, 18'h26a64, 18'h27541, 18'h28c69
  };

  typedef struct packed {
    module_class_e cls;
    logic          outside;
  } class_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // col [7:0], row [15:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // module_class [1:0], zero [7:2]
  logic        m_axis_tuser;        // outside [0]

  class_word_t class_fifo [$];
  logic [5:0]  version_reg = VERSION_RESET;
  int          idle_pct = 20;
  int          stall_left = 0;
  int          errors = 0;
  int          cycle_count = 0;

  qr_function_pattern_map_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic int mag(int x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic int eff_version(logic [5:0] ver);
    if (ver == '0) return 1;
    if (ver > MAX_VERSION) return 40;
    return int'(ver);
  endfunction

  function automatic int centre_count(int v);
    int w;
    w = 17 + 4 * v;
    if (CENTRE_3RD[v] > CENTRE_2ND[v])
      return (w - CENTRE_2ND[v]) / (CENTRE_3RD[v] - CENTRE_2ND[v]) + 1;
    return 1;
  endfunction

  // index 0 is the timing-line centre at 6
  function automatic int centre_at(int v, int k);
    int d;
    d = (CENTRE_3RD[v] > CENTRE_2ND[v]) ? CENTRE_3RD[v] - CENTRE_2ND[v] : 0;
    if (k == 0) return 6;
    return CENTRE_2ND[v] + (k - 1) * d;
  endfunction

  function automatic int align_index(int t, int v, output int off);
    int p;
    off = 0;
    for (int k = 0; k <= centre_count(v); k++) begin
      p = centre_at(v, k);
      if (mag(t - p) <= 2) begin
        off = t - p;
        return k;
      end
    end
    return -1;
  endfunction

  function automatic module_class_e finder_ring(int fx, int fy);
    int m;
    m = (mag(fx - 3) > mag(fy - 3)) ? mag(fx - 3) : mag(fy - 3);
    return (m == 2) ? CLS_LIGHT : CLS_DARK;
  endfunction

  function automatic class_word_t map_module(logic [5:0] ver, int c, int r);
    class_word_t res;
    int          v, w, kx, ky, ox, oy, k_end, m, i;
    logic [17:0] vword;
    v = eff_version(ver);
    w = 17 + 4 * v;
    res.cls = CLS_DATA;
    res.outside = 1'b0;
    if (c >= w || r >= w) begin
      res.outside = 1'b1;
      return res;
    end
    if (c <= 6 && r <= 6) res.cls = finder_ring(c, r);
    if (c >= w - 7 && r <= 6) res.cls = finder_ring(c - (w - 7), r);
    if (c <= 6 && r >= w - 7) res.cls = finder_ring(c, r - (w - 7));
    if ((c == 7 && r <= 6) || (c == w - 8 && r <= 6) || (c == 7 && r >= w - 7) ||
        (r == 7 && c <= 7) || (r == 7 && c >= w - 8) || (r == w - 8 && c <= 7))
      res.cls = CLS_LIGHT;
    if ((r == 8 && c <= 8) || (r == 8 && c >= w - 8) ||
        (c == 8 && r <= 7) || (c == 8 && r >= w - 7))
      res.cls = CLS_RSVD;
    if (r == 6 && c >= 8 && c <= w - 9) res.cls = c[0] ? CLS_LIGHT : CLS_DARK;
    if (c == 6 && r >= 8 && r <= w - 9) res.cls = r[0] ? CLS_LIGHT : CLS_DARK;
    if (v >= 2) begin
      k_end = centre_count(v);
      kx = align_index(c, v, ox);
      ky = align_index(r, v, oy);
      // the three corners under the finders carry no alignment pattern
      if (kx >= 0 && ky >= 0 && !(kx == 0 && ky == 0) &&
          !(kx == 0 && ky == k_end) && !(kx == k_end && ky == 0)) begin
        m = (mag(ox) > mag(oy)) ? mag(ox) : mag(oy);
        res.cls = (m == 1) ? CLS_LIGHT : CLS_DARK;
      end
    end
    if (v >= 7) begin
      vword = VERSION_WORDS[v - 7];
      i = -1;
      if (c <= 5 && r >= w - 11 && r <= w - 9) i = c * 3 + (r - (w - 11));
      if (r <= 5 && c >= w - 11 && c <= w - 9) i = r * 3 + (c - (w - 11));
      if (i >= 0 && i < 18) res.cls = vword[i] ? CLS_DARK : CLS_LIGHT;
    end
    if (c == 8 && r == w - 8) res.cls = CLS_DARK;
    return res;
  endfunction

  // coordinate on one axis, biased toward the function areas
  function automatic logic [7:0] pick_axis(int v);
    int w, sel;
    w = 17 + 4 * v;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 8'($urandom_range(0, 255));
    if (sel < 15) return 8'(w + int'($urandom_range(0, 3)));
    if (sel < 32) return 8'($urandom_range(0, 8));
    if (sel < 50) return 8'(w - 1 - int'($urandom_range(0, 10)));
    if (sel < 75)
      return 8'(centre_at(v, $urandom_range(0, centre_count(v))) +
                int'($urandom_range(0, 4)) - 2);
    return 8'($urandom_range(0, w - 1));
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_coord(input logic [7:0] c, input logic [7:0] r);
    s_axis_tdata <= {r, c};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    class_fifo.push_back(map_module(version_reg, c, r));
    if ($urandom_range(1, 100) <= idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (class_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_version(input logic [5:0] ver);
    wait_drained();
    cfg_wdata_i <= ver;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    version_reg = ver;
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(1, 100) <= idle_pct) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    class_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (class_fifo.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = class_fifo.pop_front();
        if (m_axis_tdata[1:0] !== want.cls) begin
          $display("%0t: module_class mismatch, expected %0d actual %0d",
                   $time, want.cls, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[7:2] !== 6'd0) begin
          $display("%0t: tdata pad mismatch, expected 0 actual %h",
                   $time, m_axis_tdata[7:2]);
          errors++;
        end
        if (m_axis_tuser !== want.outside) begin
          $display("%0t: outside mismatch, expected %b actual %b",
                   $time, want.outside, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, class_fifo.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // version 1 straight out of reset, width 21
  task automatic test_reset_template();
    send_coord(8'd0, 8'd0);
    send_coord(8'd1, 8'd1);
    send_coord(8'd7, 8'd0);
    send_coord(8'd8, 8'd0);
    send_coord(8'd10, 8'd6);
    send_coord(8'd6, 8'd9);
    send_coord(8'd8, 8'd13);
    send_coord(8'd20, 8'd20);
    send_coord(8'd12, 8'd12);
    send_coord(8'd21, 8'd0);
    send_coord(8'd0, 8'd21);
    send_coord(8'd255, 8'd255);
  endtask

  task automatic test_version_limits();
    set_version(6'd40);
    send_coord(8'd176, 8'd176);
    send_coord(8'd177, 8'd0);
    send_coord(8'd170, 8'd170);
    send_coord(8'd169, 8'd170);
    send_coord(8'd6, 8'd170);    // alignment skipped under the bottom-left finder
    send_coord(8'd6, 8'd30);     // alignment overrides the timing line
    send_coord(8'd0, 8'd166);
    send_coord(8'd166, 8'd5);
    send_coord(8'd8, 8'd169);
    set_version(6'd0);
    send_coord(8'd20, 8'd0);
    send_coord(8'd21, 8'd0);
    set_version(6'd63);
    send_coord(8'd176, 8'd0);
    set_version(6'd41);
    send_coord(8'd100, 8'd6);
  endtask

  task automatic test_random_versions();
    logic [5:0] ver_list [NUM_PHASES];
    int         pct_list [NUM_PHASES];
    int         v;
    ver_list = '{6'd7, 6'd2, 6'd6, 6'd14, 6'd13, 6'd21, 6'd20, 6'd28,
                 6'd27, 6'd35, 6'd34, 6'd1, 6'd0, 6'd63, 6'd10, 6'd40};
    pct_list = '{25, 0, 40, 10, 60, 0, 30, 15, 50, 20, 0, 35, 10, 45, 0, 0};
    ver_list[14] = 6'($urandom_range(1, 40));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_version(ver_list[p]);
      idle_pct = pct_list[p];
      v = eff_version(ver_list[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 3 && n == PHASE_WORDS / 2) wait_drained();
        send_coord(pick_axis(v), pick_axis(v));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_template();
    test_version_limits();
    test_random_versions();
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
